[hdl/nfa_pkg.sv]
// ----------------------------------------------------------------------------
// nfa_pkg: shared types and constants for the next-fit slot allocator
// sizes of the slot pool, request codes and the result record
// ----------------------------------------------------------------------------
package nfa_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int SLOT_W     = (POOL_SLOTS > 2) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

  // field widths of the item channels
  localparam int ACTION_W = 2;
  localparam int IDX_W    = 6;
  localparam int USED_W   = 7;

  // encoder split: groups of eight slots
  localparam int GRP_W     = 8;
  localparam int GRP_BIT_W = 3;
  localparam int NGRP      = (POOL_SLOTS + GRP_W - 1) / GRP_W;
  localparam int GRP_SEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_COUNT = 2'd3
  } nfa_action_e;

  typedef struct packed {
    logic [IDX_W-1:0]  granted_slot;
    logic              success;
    logic [USED_W-1:0] used_count;
  } nfa_result_t;

endpackage

[hdl/nfa_search.sv]
// ----------------------------------------------------------------------------
// nfa_search: rotating free-slot search
// finds the first free slot at or after the pointer, wrapping to slot zero
// ----------------------------------------------------------------------------
module nfa_search import nfa_pkg::*; (
  input  logic [POOL_SLOTS-1:0] occupied_i,
  input  logic [SLOT_W-1:0]     pointer_i,
  output logic                  found_o,
  output logic [SLOT_W-1:0]     slot_o
);

  logic [SLOT_W-1:0]       ptr_eff;
  logic [POOL_SLOTS-1:0]   free_vec;
  logic [POOL_SLOTS-1:0]   upper_vec;
  logic [POOL_SLOTS-1:0]   sel_vec;
  logic [NGRP*GRP_W-1:0]   padded;
  logic [NGRP-1:0]         grp_any;
  logic [GRP_SEL_W-1:0]    grp_idx;
  logic [GRP_W-1:0]        grp_bits;
  logic [GRP_BIT_W-1:0]    bit_idx;

  // a pointer past the pool end searches from zero
  assign ptr_eff  = (int'(pointer_i) >= POOL_SLOTS) ? '0 : pointer_i;
  assign free_vec = ~occupied_i;
  assign found_o  = |free_vec;

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      upper_vec[i] = free_vec[i] && (SLOT_W'(i) >= ptr_eff);
    end
  end

  // free slots at or above the pointer win, else wrap around
  assign sel_vec = (|upper_vec) ? upper_vec : free_vec;

  // two-level priority encoder: group first, then bit within group
  always_comb begin
    padded = '0;
    padded[POOL_SLOTS-1:0] = sel_vec;
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |padded[g*GRP_W +: GRP_W];
    end
    grp_idx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_idx = GRP_SEL_W'(g);
      end
    end
    grp_bits = padded[grp_idx*GRP_W +: GRP_W];
    bit_idx  = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_idx = GRP_BIT_W'(b);
      end
    end
  end

  assign slot_o = SLOT_W'({grp_idx, bit_idx});

endmodule

[hdl/nfa_pool.sv]
// ----------------------------------------------------------------------------
// nfa_pool: occupancy map, search pointer and used-slot counter
// applies one request per fire and forms its result
// ----------------------------------------------------------------------------
module nfa_pool import nfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  nfa_action_e       action_i,
  input  logic [IDX_W-1:0]  slot_index_i,
  output nfa_result_t       result_o
);

  logic [POOL_SLOTS-1:0] occ_q, occ_d;
  logic [SLOT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  found;
  logic [SLOT_W-1:0]     found_slot;
  logic [SLOT_W-1:0]     free_slot;
  logic                  free_hit;

  nfa_search u_search (
    .occupied_i (occ_q),
    .pointer_i  (ptr_q),
    .found_o    (found),
    .slot_o     (found_slot)
  );

  assign free_slot = SLOT_W'(slot_index_i);
  assign free_hit  = (int'(slot_index_i) < POOL_SLOTS) && occ_q[free_slot];

  always_comb begin
    occ_d                 = occ_q;
    ptr_d                 = ptr_q;
    cnt_d                 = cnt_q;
    result_o.granted_slot = '0;
    result_o.success      = 1'b1;
    unique case (action_i)
      ACT_ALLOC: begin
        if (found) begin
          occ_d[found_slot]     = 1'b1;
          result_o.granted_slot = IDX_W'(found_slot);
          ptr_d = (found_slot == SLOT_W'(POOL_SLOTS - 1)) ? '0 : found_slot + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          result_o.success = 1'b0;
        end
      end
      ACT_FREE: begin
        if (free_hit) begin
          occ_d[free_slot] = 1'b0;
          cnt_d            = cnt_q - 1'b1;
        end
      end
      ACT_CLEAR: begin
        occ_d = '0;
        ptr_d = '0;
        cnt_d = '0;
      end
      ACT_COUNT: begin
      end
      default: begin
      end
    endcase
    result_o.used_count = USED_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      ptr_q <= '0;
      cnt_q <= '0;
    end else if (fire_i) begin
      occ_q <= occ_d;
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hdl/next_fit_slot_allocator.sv]
// ----------------------------------------------------------------------------
// next_fit_slot_allocator: next-fit slot pool allocator
// keeps a used map over the pool and hands out free slots round-robin
// ----------------------------------------------------------------------------
// usage
//   request channel: in_valid_i / in_ready_o carry action_i and slot_index_i
//     (allocate, free slot, clear all, count used)
//   result channel: out_valid_o / out_ready_i carry granted_slot_o, success_o
//     and used_count_o, exactly one result per request, in request order
//   a taken request passes the request register, then the result register
//   throughput: one request per cycle while the receiver takes results; the
//     combinational update of the map, pointer and counter between the
//     request register and the result register sets that figure
//   allocate searches from the pointer with wrap-around; a full pool gives
//     success 0, slot 0 and leaves the map and pointer alone
//   reset empties the map, zeroes the pointer and the count and drops both
//     pipeline registers; no clearing pass is needed
//   when the receiver stalls, the result register holds and the request
//     register fills; in_ready_o then drops until the result is taken
// ----------------------------------------------------------------------------
module next_fit_slot_allocator import nfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [IDX_W-1:0]    slot_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IDX_W-1:0]    granted_slot_o,
  output logic                success_o,
  output logic [USED_W-1:0]   used_count_o
);

  // request register
  logic                 req_valid_q;
  nfa_action_e          req_action_q;
  logic [IDX_W-1:0]     req_slot_q;

  // result register
  logic                 res_valid_q;
  nfa_result_t          res_q;
  nfa_result_t          res_d;

  logic                 fire;

  // a held request is processed once the result register can take it
  assign fire       = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || fire;

  nfa_pool u_pool (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .action_i     (req_action_q),
    .slot_index_i (req_slot_q),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_action_q <= nfa_action_e'(action_i);
      req_slot_q   <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign granted_slot_o = res_q.granted_slot;
  assign success_o      = res_q.success;
  assign used_count_o   = res_q.used_count;

endmodule

[hdl/nfa_checker.sv]
// ----------------------------------------------------------------------------
// nfa_checker: port-level checks for the next-fit slot allocator
// watches the request and result channels for consistency over time
// ----------------------------------------------------------------------------
module nfa_checker import nfa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [IDX_W-1:0]    granted_slot_o,
  input logic                success_o,
  input logic [USED_W-1:0]   used_count_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_slot_o)
      && $stable(success_o) && $stable(used_count_o))
    else $error("stalled result changed");

  // failed allocate only on a full pool, and grants nothing
  a_fail_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |->
      granted_slot_o == '0 && used_count_o == USED_W'(POOL_SLOTS))
    else $error("allocate failed on a pool that is not full");

  // count never exceeds the pool
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(used_count_o) <= POOL_SLOTS)
    else $error("used count beyond pool size");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // a request taken behind a stalled result blocks the input until the
  // receiver takes the result
  a_no_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o && !out_ready_i |=>
      !in_ready_o || out_ready_i)
    else $error("accepted past a stalled result without backpressure");

endmodule

bind next_fit_slot_allocator nfa_checker u_nfa_checker (.*);

[bench/tb_next_fit_slot_allocator.sv]
// ----------------------------------------------------------------------------
// tb_next_fit_slot_allocator: self-checking bench for the slot allocator
// drives allocate, free, clear and count requests under random idling on
// both channels, predicts every result from a local copy of the used map
// and search pointer, and compares each returned item field by field
// ----------------------------------------------------------------------------
module tb_next_fit_slot_allocator import nfa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake on either side before the run is declared hung
  localparam int HANG_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    nfa_action_e      action;
    logic [IDX_W-1:0] idx;
  } slot_req_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i;
  logic [IDX_W-1:0]    slot_index_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [IDX_W-1:0]    granted_slot_o;
  logic                success_o;
  logic [USED_W-1:0]   used_count_o;

  next_fit_slot_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .slot_index_i  (slot_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .granted_slot_o(granted_slot_o),
    .success_o     (success_o),
    .used_count_o  (used_count_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // requests waiting to be driven, results the pool owes us
  slot_req_t   pending_requests[$];
  nfa_result_t owed_responses[$];

  // shadow of the pool: one bit per slot plus the next-fit pointer
  logic [POOL_SLOTS-1:0] slot_used_map = '0;
  logic [SLOT_W-1:0]     next_probe    = '0;

  int  fail_count = 0;
  int  queued_items = 0;
  bit  req_taken = 1'b0;
  bit  res_taken = 1'b0;
  int  send_gap = 0;
  int  send_mode = 0;
  int  recv_stall = 0;
  int  recv_mode = 0;

  // apply one request to the shadow pool and return what the block should say
  function automatic nfa_result_t pool_apply(nfa_action_e act, logic [IDX_W-1:0] idx);
    nfa_result_t      res;
    logic [SLOT_W-1:0] probe;
    bit               found;
    res.granted_slot = '0;
    res.success      = 1'b1;
    found            = 1'b0;
    case (act)
      ACT_ALLOC: begin
        // next-fit: scan from the pointer, wrapping round the pool
        for (int k = 0; k < POOL_SLOTS; k++) begin
          probe = next_probe + SLOT_W'(k);
          if (!found && !slot_used_map[probe]) begin
            found                = 1'b1;
            slot_used_map[probe] = 1'b1;
            res.granted_slot     = probe;
            next_probe           = probe + 1'b1;
          end
        end
        // pool full: map and pointer stay as they are
        if (!found) res.success = 1'b0;
      end
      ACT_FREE: begin
        // freeing an unused slot is harmless
        slot_used_map[idx] = 1'b0;
      end
      ACT_CLEAR: begin
        slot_used_map = '0;
        next_probe    = '0;
      end
      default: begin
        // count only reports
      end
    endcase
    res.used_count = USED_W'($countones(slot_used_map));
    return res;
  endfunction

  // idle cycles before the next item; mode 0 never idles, 1 idles now and
  // then, 2 idles a lot
  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // request side: a new item goes out once the previous one is taken and
  // its drawn gap has run out
  always @(negedge clk_i) begin
    slot_req_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (send_gap > 0 || pending_requests.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          nxt = pending_requests.pop_front();
          action_i     <= nxt.action;
          slot_index_i <= nxt.idx;
          in_valid_i   <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_mode = $urandom_range(0, 2);
          send_gap = draw_wait(send_mode);
        end
      end
    end
  end

  // result side: after each taken result hold ready low for a drawn stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        if ($urandom_range(0, 39) == 0) recv_mode = $urandom_range(0, 2);
        recv_stall = draw_wait(recv_mode);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: predict on every taken request, check every taken result
  always @(posedge clk_i) begin
    nfa_result_t want;
    req_taken = rst_ni && in_valid_i && in_ready_o;
    res_taken = rst_ni && out_valid_o && out_ready_i;
    if (req_taken) begin
      owed_responses.push_back(pool_apply(nfa_action_e'(action_i), slot_index_i));
    end
    if (res_taken) begin
      if (owed_responses.size() == 0) begin
        $error("result with none owed: granted_slot %0d success %0d used_count %0d",
               granted_slot_o, success_o, used_count_o);
        fail_count++;
      end else begin
        want = owed_responses.pop_front();
        if (granted_slot_o !== want.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want.granted_slot, granted_slot_o);
          fail_count++;
        end
        if (success_o !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, success_o);
          fail_count++;
        end
        if (used_count_o !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count, used_count_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no handshake for %0d cycles", HANG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_req(nfa_action_e act, int idx);
    slot_req_t r;
    r.action = act;
    r.idx    = IDX_W'(idx);
    pending_requests.push_back(r);
    queued_items++;
  endtask

  // sender holds off until every owed result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || owed_responses.size() != 0);
    @(posedge clk_i);
  endtask

  // one stretch of random requests; the flavor decides the action mix
  //   0 fill: mostly allocate, runs the pool into full and wraps the pointer
  //   1 churn: allocate and free about equally
  //   2 noise: any action, clear included
  task automatic push_segment(int flavor, int len);
    int roll;
    nfa_action_e act;
    for (int n = 0; n < len; n++) begin
      roll = $urandom_range(0, 99);
      case (flavor)
        0:       act = (roll < 85) ? ACT_ALLOC : (roll < 95) ? ACT_FREE : ACT_COUNT;
        1:       act = (roll < 45) ? ACT_ALLOC : (roll < 85) ? ACT_FREE : ACT_COUNT;
        default: act = nfa_action_e'($urandom_range(0, 3));
      endcase
      push_req(act, $urandom_range(0, POOL_SLOTS - 1));
    end
  endtask

  // stimulus and end of run
  initial begin
    int flavor;
    int segs;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_ready_i  = 1'b0;
    action_i     = ACT_COUNT;
    slot_index_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: empty count, back-to-back grants, frees of used and unused
    // slots, next-fit skipping a freed slot, clear resetting the pointer
    push_req(ACT_COUNT, 63);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_ALLOC, 63);
    push_req(ACT_ALLOC, 21);
    push_req(ACT_FREE,  1);
    push_req(ACT_FREE,  1);
    push_req(ACT_FREE,  63);
    push_req(ACT_ALLOC, 63);
    push_req(ACT_COUNT, 42);
    push_req(ACT_CLEAR, 42);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_FREE,  0);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_COUNT, 0);
    push_req(ACT_FREE,  0);
    push_req(ACT_CLEAR, 63);
    wait_drained();

    // fill past full so the pointer wraps and allocate reports a full pool,
    // then free the top slot and grab it again
    for (int n = 0; n < 66; n++) push_req(ACT_ALLOC, n);
    push_req(ACT_FREE,  63);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_ALLOC, 0);

    // random part: mostly fill and churn stretches, a few noisy ones
    segs = 0;
    while (queued_items < RANDOM_ITEMS) begin
      flavor = $urandom_range(0, 9);
      if (flavor < 5) begin
        push_segment(0, $urandom_range(40, 90));
      end else if (flavor < 8) begin
        push_segment(1, $urandom_range(20, 60));
      end else if (flavor == 8) begin
        push_segment(2, $urandom_range(10, 30));
      end else begin
        push_req(ACT_CLEAR, $urandom_range(0, POOL_SLOTS - 1));
        push_segment(0, $urandom_range(10, 70));
      end
      segs++;
      if (segs % 6 == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
